// ----- rtl/core/clock_offset_averager_top_defines.svh -----
// Assertion macros shared by the clock offset averager RTL
`ifndef CLOCK_OFFSET_AVERAGER_TOP_DEFINES_SVH
`define CLOCK_OFFSET_AVERAGER_TOP_DEFINES_SVH

// Same-cycle implication, held off during reset
`define COA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, held off during reset
`define COA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// ----- rtl/core/coa_pkg.sv -----
// Shared constants, payload types and control types for the clock offset averager
package coa_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int TIME_BITS_DEF = 48;

    localparam int IN_BITS     = 48;
    localparam int OFFSET_BITS = 51;
    localparam int SUM_BITS    = 57;
    localparam int ADJ_BITS    = 52;
    localparam int NODE_BITS   = 6;
    localparam int CNT_BITS    = 7;

    localparam logic [CNT_BITS-1:0] NODE_COUNT_RST = CNT_BITS'(2);

    typedef struct packed {
        logic [IN_BITS-1:0] send_time;
        logic [IN_BITS-1:0] reply_time;
        logic [IN_BITS-1:0] receive_time;
    } t_in_req;

    typedef struct packed {
        logic [NODE_BITS-1:0]       node_index;
        logic signed [ADJ_BITS-1:0] adjustment;
        logic                       last;
    } t_out_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACCUM,
        S_DIV_GO,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic accum;
        logic div_start;
        logic set_avg;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic round_end;
        logic div_done;
        logic out_free;
        logic emit_last;
    } t_status;

endpackage

// ----- rtl/core/clock_offset_averager_top.sv -----
// Top level of the clock offset averager: controller plus datapath
// Usage:
//   Input channel (i_in_valid / o_in_ready, i_in_req) takes one request per
//   follower: poll send time, reported follower time and reply receive time.
//   Each request is captured, then written to the offset store and added to the sum.
//   The request that completes a round (node_count - 1 requests) adds a serial
//   divide: a start step, 57 quotient steps and a done flag, one bit per
//   cycle through the restoring divider.
//   Results (o_out_valid / i_out_ready, o_out_req) follow at one per cycle while
//   the receiver is ready, from the offset store read port: node 0 first,
//   o_out_req.last on the final one. A stalled receiver holds the output register
//   and pauses the result sequence; the next round's requests are taken once the
//   last result is loaded. The user must write node_count through i_cfg_we /
//   i_cfg_wdata only while the block is idle; the block itself does not enforce
//   this. Synchronous reset clears the sum, request count and output valid, and
//   sets node_count to 2; the offset store is not cleared.
module clock_offset_averager_top #(
    parameter int MAX_NODES = coa_pkg::MAX_NODES_DEF,
    parameter int TIME_BITS = coa_pkg::TIME_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [coa_pkg::CNT_BITS-1:0]  i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  coa_pkg::t_in_req              i_in_req,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output coa_pkg::t_out_req             o_out_req
);

    coa_pkg::t_cmd    cmd;
    coa_pkg::t_status status;

    coa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    coa_dpath #(
        .MAX_NODES (MAX_NODES),
        .TIME_BITS (TIME_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_req    (i_in_req),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req)
    );

endmodule

// ----- rtl/core/coa_div.sv -----
// Restoring divider, one quotient bit per cycle, for the offset average
module coa_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [coa_pkg::SUM_BITS-1:0]  i_dividend,
    input  logic [coa_pkg::CNT_BITS-1:0]  i_divisor,
    output logic [coa_pkg::SUM_BITS-1:0]  o_quotient,
    output logic                          o_done
);

    localparam int STEP_BITS = $clog2(coa_pkg::SUM_BITS);
    localparam int REM_BITS  = coa_pkg::CNT_BITS + 1;
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(coa_pkg::SUM_BITS - 1);

    logic [coa_pkg::SUM_BITS-1:0] r_quo;
    logic [coa_pkg::SUM_BITS-1:0] n_quo;
    logic [REM_BITS-1:0]          r_rem;
    logic [REM_BITS-1:0]          n_rem;
    logic [coa_pkg::CNT_BITS-1:0] r_div;
    logic [STEP_BITS-1:0]         r_cnt;
    logic                         r_busy;
    logic                         r_done;
    logic [REM_BITS-1:0]          shifted;
    logic                         fits;

    always_comb begin
        shifted = {r_rem[REM_BITS-2:0], r_quo[coa_pkg::SUM_BITS-1]};
        fits    = shifted >= {1'b0, r_div};
        n_rem   = fits ? (shifted - {1'b0, r_div}) : shifted;
        n_quo   = {r_quo[coa_pkg::SUM_BITS-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
            r_cnt <= r_cnt + STEP_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == LAST_STEP);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_cnt == LAST_STEP) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

// ----- rtl/core/coa_dpath.sv -----
// Datapath: offset store, running sum, divider and result register
module coa_dpath #(
    parameter int MAX_NODES = coa_pkg::MAX_NODES_DEF,
    parameter int TIME_BITS = coa_pkg::TIME_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [coa_pkg::CNT_BITS-1:0]  i_cfg_wdata,
    input  coa_pkg::t_in_req              i_in_req,
    input  coa_pkg::t_cmd                 i_cmd,
    output coa_pkg::t_status              o_status,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output coa_pkg::t_out_req             o_out_req
);

    localparam int IDX_BITS = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
    localparam int EFF_TIME = (TIME_BITS < coa_pkg::IN_BITS) ? TIME_BITS : coa_pkg::IN_BITS;
    localparam logic [coa_pkg::IN_BITS-1:0] TIME_MASK =
        {coa_pkg::IN_BITS{1'b1}} >> (coa_pkg::IN_BITS - EFF_TIME);
    localparam logic [coa_pkg::CNT_BITS-1:0] MAX_CNT = coa_pkg::CNT_BITS'(MAX_NODES);
    localparam logic [coa_pkg::CNT_BITS-1:0] MIN_CNT = coa_pkg::NODE_COUNT_RST;
    localparam logic [coa_pkg::CNT_BITS-1:0] ONE_CNT = coa_pkg::CNT_BITS'(1);
    localparam int SEXT_BITS = coa_pkg::SUM_BITS - coa_pkg::OFFSET_BITS;

    logic [coa_pkg::CNT_BITS-1:0]    r_node_count;
    logic [coa_pkg::IN_BITS-1:0]     r_send;
    logic [coa_pkg::IN_BITS-1:0]     r_reply;
    logic [coa_pkg::IN_BITS-1:0]     r_recv;
    logic [coa_pkg::SUM_BITS-1:0]    r_sum;
    logic [coa_pkg::SUM_BITS-1:0]    n_sum;
    logic [coa_pkg::NODE_BITS-1:0]   r_items;
    logic [coa_pkg::NODE_BITS-1:0]   n_items;
    logic                            r_neg;
    logic [coa_pkg::ADJ_BITS-1:0]    r_avg;
    logic [coa_pkg::ADJ_BITS-1:0]    n_avg;
    logic [coa_pkg::NODE_BITS-1:0]   r_k;
    logic [coa_pkg::OFFSET_BITS-1:0] r_rd_data;
    logic [coa_pkg::OFFSET_BITS-1:0] r_mem [MAX_NODES];
    coa_pkg::t_out_req               r_out;
    coa_pkg::t_out_req               n_out;
    logic                            r_out_valid;

    logic [coa_pkg::CNT_BITS-1:0]    n_eff;
    logic [coa_pkg::OFFSET_BITS-1:0] offset;
    logic [coa_pkg::NODE_BITS-1:0]   k_inc;
    logic [IDX_BITS-1:0]             wr_addr;
    logic [IDX_BITS-1:0]             rd_addr;
    logic [coa_pkg::SUM_BITS-1:0]    mag;
    logic [coa_pkg::SUM_BITS-1:0]    quotient;
    logic                            div_done;
    logic [coa_pkg::ADJ_BITS-1:0]    adj;

    always_comb begin
        n_eff = r_node_count;
        if (r_node_count < MIN_CNT) begin
            n_eff = MIN_CNT;
        end else if (r_node_count > MAX_CNT) begin
            n_eff = MAX_CNT;
        end
    end

    always_comb begin
        offset  = coa_pkg::OFFSET_BITS'(r_send) + coa_pkg::OFFSET_BITS'(r_recv)
                - (coa_pkg::OFFSET_BITS'(r_reply) << 1);
        n_sum   = r_sum + {{SEXT_BITS{offset[coa_pkg::OFFSET_BITS-1]}}, offset};
        n_items = r_items + coa_pkg::NODE_BITS'(1);
        wr_addr = n_items[IDX_BITS-1:0];
        k_inc   = r_k + coa_pkg::NODE_BITS'(1);
        rd_addr = i_cmd.emit ? k_inc[IDX_BITS-1:0] : r_k[IDX_BITS-1:0];
        mag     = r_sum[coa_pkg::SUM_BITS-1] ? (-r_sum) : r_sum;
        n_avg   = r_neg ? (-quotient[coa_pkg::ADJ_BITS-1:0])
                        : quotient[coa_pkg::ADJ_BITS-1:0];
        adj     = (r_k == '0) ? r_avg
                : r_avg - {r_rd_data[coa_pkg::OFFSET_BITS-1], r_rd_data};
        n_out.node_index = r_k;
        n_out.adjustment = adj;
        n_out.last       = ({1'b0, r_k} == (n_eff - ONE_CNT));
    end

    coa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (mag),
        .i_divisor  (n_eff),
        .o_quotient (quotient),
        .o_done     (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.accum) begin
            r_mem[wr_addr] <= offset;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_send  <= i_in_req.send_time & TIME_MASK;
            r_reply <= i_in_req.reply_time & TIME_MASK;
            r_recv  <= i_in_req.receive_time & TIME_MASK;
        end
        if (i_cmd.div_start) begin
            r_neg <= r_sum[coa_pkg::SUM_BITS-1];
        end
        if (i_cmd.set_avg) begin
            r_avg <= n_avg;
        end
        if (i_cmd.set_avg) begin
            r_k <= '0;
        end else if (i_cmd.emit) begin
            r_k <= k_inc;
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= coa_pkg::NODE_COUNT_RST;
            r_sum        <= '0;
            r_items      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
            if (i_cmd.div_start) begin
                r_sum <= '0;
            end else if (i_cmd.accum) begin
                r_sum <= n_sum;
            end
            if (i_cmd.accum) begin
                r_items <= o_status.round_end ? '0 : n_items;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.round_end = ({1'b0, r_items} + ONE_CNT) >= (n_eff - ONE_CNT);
    assign o_status.div_done  = div_done;
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.emit_last = n_out.last;

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule

// ----- rtl/core/coa_ctrl.sv -----
// Controller state machine sequencing load, divide and result phases
`include "clock_offset_averager_top_defines.svh"

module coa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  coa_pkg::t_status  i_status,
    output coa_pkg::t_cmd     o_cmd
);

    coa_pkg::t_state r_state;
    coa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= coa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            coa_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = coa_pkg::S_ACCUM;
                end
            end
            coa_pkg::S_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state     = i_status.round_end ? coa_pkg::S_DIV_GO : coa_pkg::S_IDLE;
            end
            coa_pkg::S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = coa_pkg::S_DIV;
            end
            coa_pkg::S_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.set_avg = 1'b1;
                    n_state       = coa_pkg::S_EMIT;
                end
            end
            coa_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = coa_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = coa_pkg::S_IDLE;
            end
        endcase
    end

    `COA_ASSERT_NXT(a_capture_then_accum, i_clk, i_rst_n, o_cmd.capture, r_state == coa_pkg::S_ACCUM)
    `COA_ASSERT_NXT(a_round_end_to_div, i_clk, i_rst_n, o_cmd.accum && i_status.round_end, r_state == coa_pkg::S_DIV_GO)
    `COA_ASSERT_IMP(a_done_only_in_div, i_clk, i_rst_n, i_status.div_done, r_state == coa_pkg::S_DIV)
    `COA_ASSERT_NXT(a_last_to_idle, i_clk, i_rst_n, o_cmd.emit && i_status.emit_last, r_state == coa_pkg::S_IDLE)

endmodule

// ----- sim/clock_offset_averager_checker.sv -----
// Checker for the clock offset averager: predicts each round's adjustments and compares results
module clock_offset_averager_checker
    import coa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CNT_BITS-1:0] i_cfg_wdata,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  t_in_req             i_in_req,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  t_out_req            i_out_req,
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_adjustments,
    output int                  o_rounds
);

    localparam int MIN_NODES = 2;

    logic [OFFSET_BITS-1:0] follower_offset [MAX_NODES_DEF];
    logic [SUM_BITS-1:0]    round_sum   = '0;
    logic [NODE_BITS-1:0]   round_count = '0;
    logic [CNT_BITS-1:0]    node_count  = NODE_COUNT_RST;
    t_out_req               due_adjustments [$];

    initial begin
        o_errors      = 0;
        o_pending     = 0;
        o_adjustments = 0;
        o_rounds      = 0;
    end

    function automatic int clamp_nodes(logic [CNT_BITS-1:0] value);
        if (value < MIN_NODES) begin
            return MIN_NODES;
        end
        if (value > MAX_NODES_DEF) begin
            return MAX_NODES_DEF;
        end
        return int'(value);
    endfunction

    function automatic logic signed [63:0] widen(logic [63:0] value, int bits);
        logic [63:0] field_mask;
        logic [63:0] masked;
        field_mask = (64'd1 << bits) - 64'd1;
        masked     = value & field_mask;
        if (masked[bits-1]) begin
            masked = masked | ~field_mask;
        end
        return signed'(masked);
    endfunction

    // Fold one follower request into the round; close the round when enough have come
    task automatic absorb_request(t_in_req req);
        logic [63:0]        send_t;
        logic [63:0]        reply_t;
        logic [63:0]        recv_t;
        logic [63:0]        offset;
        logic [63:0]        magnitude;
        logic signed [63:0] total;
        logic signed [63:0] average;
        logic signed [63:0] correction;
        logic [NODE_BITS-1:0] slot;
        t_out_req           item;
        int                 nodes;
        nodes   = clamp_nodes(node_count);
        send_t  = 64'(req.send_time);
        reply_t = 64'(req.reply_time);
        recv_t  = 64'(req.receive_time);
        offset  = (send_t + recv_t - (reply_t << 1)) & ((64'd1 << OFFSET_BITS) - 64'd1);
        slot    = round_count + NODE_BITS'(1);
        follower_offset[slot] = offset[OFFSET_BITS-1:0];
        round_sum   = round_sum + SUM_BITS'(widen(offset, OFFSET_BITS));
        round_count = round_count + NODE_BITS'(1);
        if (int'(round_count) < nodes - 1) begin
            return;
        end
        total     = widen(64'(round_sum), SUM_BITS);
        magnitude = (total < 0) ? 64'(-total) : 64'(total);
        average   = signed'(magnitude / 64'(nodes));
        if (total < 0) begin
            average = -average;
        end
        for (int k = 0; k < nodes; k++) begin
            correction = average;
            if (k != 0) begin
                correction = average - widen(64'(follower_offset[k]), OFFSET_BITS);
            end
            item.node_index = NODE_BITS'(k);
            item.adjustment = ADJ_BITS'(correction);
            item.last       = (k == nodes - 1);
            due_adjustments.push_back(item);
        end
        round_sum   = '0;
        round_count = '0;
        o_rounds++;
    endtask

    task automatic check_adjustment(t_out_req got);
        t_out_req want;
        if (due_adjustments.size() == 0) begin
            $error("adjustment for node %0d with none outstanding", got.node_index);
            o_errors++;
            return;
        end
        want = due_adjustments.pop_front();
        if (got.node_index !== want.node_index) begin
            $error("node_index: expected %0d, got %0d", want.node_index, got.node_index);
            o_errors++;
        end
        if (got.adjustment !== want.adjustment) begin
            $error("adjustment: expected %0d, got %0d", want.adjustment, got.adjustment);
            o_errors++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            o_errors++;
        end
        o_adjustments++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            round_sum   = '0;
            round_count = '0;
            node_count  = NODE_COUNT_RST;
            due_adjustments.delete();
        end else begin
            if (i_cfg_we) begin
                node_count = i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready) begin
                absorb_request(i_in_req);
            end
            if (i_out_valid && i_out_ready) begin
                check_adjustment(i_out_req);
            end
        end
        o_pending = due_adjustments.size();
    end

endmodule

// ----- sim/clock_offset_averager_top_test.sv -----
// Testbench top for the clock offset averager: clock, reset, stimulus, idling and verdict
module clock_offset_averager_top_test;
    import coa_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 80;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_REQUESTS = 40;
    localparam int MIN_NODES      = 2;
    localparam logic [IN_BITS-1:0] TIME_MAX = '1;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CNT_BITS-1:0] cfg_wdata = '0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    t_in_req             in_req    = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    t_out_req            out_req;

    int errors;
    int pending;
    int adjustments;
    int rounds;
    int requests_sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    always #HALF_PERIOD clk = ~clk;

    clock_offset_averager_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_req   (out_req)
    );

    clock_offset_averager_checker adjustment_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_req      (in_req),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_req     (out_req),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_adjustments (adjustments),
        .o_rounds      (rounds)
    );

    initial begin
        #3000000;
        $display("clock_offset_averager_top_test: done, errors");
        $finish;
    end

    // Result side: random stalls, or a long hold when one is asked for
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            out_ready   <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_requests;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic t_in_req make_request();
        t_in_req            req;
        logic [IN_BITS-1:0] base;
        int                 kind;
        int                 round_trip;
        int                 skew;
        kind       = $urandom_range(99);
        base       = IN_BITS'({$urandom(), $urandom()});
        round_trip = $urandom_range(2, 4000);
        skew       = int'($urandom_range(2000000)) - 1000000;
        if (kind < 70) begin
            req.send_time    = base;
            req.receive_time = base + IN_BITS'(round_trip);
            req.reply_time   = base + IN_BITS'(round_trip / 2) + IN_BITS'(skew);
        end else if (kind < 90) begin
            req.send_time    = IN_BITS'({$urandom(), $urandom()});
            req.reply_time   = IN_BITS'({$urandom(), $urandom()});
            req.receive_time = IN_BITS'({$urandom(), $urandom()});
        end else begin
            req.send_time    = $urandom_range(1) ? TIME_MAX : '0;
            req.reply_time   = $urandom_range(1) ? TIME_MAX : '0;
            req.receive_time = $urandom_range(1) ? TIME_MAX : '0;
        end
        return req;
    endfunction

    // Entered and left at a falling edge
    task automatic send_request(t_in_req req);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        requests_sent++;
    endtask

    task automatic send_times(logic [IN_BITS-1:0] send_t, logic [IN_BITS-1:0] reply_t,
                              logic [IN_BITS-1:0] recv_t);
        t_in_req req;
        req.send_time    = send_t;
        req.reply_time   = reply_t;
        req.receive_time = recv_t;
        send_request(req);
    endtask

    // Drop valid, wait out every result, then let the block go quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_node_count(logic [CNT_BITS-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial begin
        logic [CNT_BITS-1:0] setting;
        int                  nodes;
        int                  repeats;
        int                  phase_requests;
        bit                  opening_round;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 35;
        recv_idle_pct = 64;

        // two nodes out of reset: zeros, largest and smallest offsets, odd sums
        send_times('0, '0, '0);
        send_times(TIME_MAX, '0, TIME_MAX);
        send_times('0, TIME_MAX, '0);
        send_times(IN_BITS'(1), IN_BITS'(1), '0);
        send_times(IN_BITS'(1), '0, '0);

        // node counts below range act as two
        write_node_count(CNT_BITS'(0));
        send_request(make_request());
        write_node_count(CNT_BITS'(1));
        send_request(make_request());

        write_node_count(CNT_BITS'(3));
        send_times({IN_BITS/2{2'b10}}, {IN_BITS/2{2'b01}}, {IN_BITS/2{2'b10}});
        send_times({IN_BITS/2{2'b01}}, {IN_BITS/2{2'b10}}, {IN_BITS/2{2'b01}});

        // node count lowered partway through a round
        write_node_count(CNT_BITS'(6));
        repeat (3) send_request(make_request());
        write_node_count(CNT_BITS'(3));
        send_request(make_request());

        // node count raised partway through a round
        write_node_count(CNT_BITS'(3));
        send_request(make_request());
        write_node_count(CNT_BITS'(5));
        repeat (3) send_request(make_request());

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 35;
                    recv_idle_pct = 64;
                end
                1: begin
                    send_idle_pct = 64;
                    recv_idle_pct = 35;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_requests = 0;
            opening_round  = 1'b1;
            while (phase_requests < PHASE_REQUESTS) begin
                if (opening_round) begin
                    setting = (phase == 0) ? CNT_BITS'(MAX_NODES_DEF) :
                              (phase == 1) ? '1 : CNT_BITS'(3);
                end else begin
                    setting = CNT_BITS'($urandom_range(9));
                end
                write_node_count(setting);
                nodes = (setting < MIN_NODES) ? MIN_NODES :
                        (setting > MAX_NODES_DEF) ? MAX_NODES_DEF : int'(setting);
                repeats = $urandom_range(1, 3);
                if (opening_round) begin
                    repeats = 1;
                end
                if (opening_round && phase == 2) begin
                    // hold the result side while rounds keep coming, to back up the input
                    repeats = 8;
                    hold_requests <= hold_requests + 1;
                end
                repeat (repeats) begin
                    repeat (nodes - 1) begin
                        send_request(make_request());
                        phase_requests++;
                    end
                end
                opening_round = 1'b0;
            end
        end

        settle();
        $display("clock offset averager: %0d requests, %0d adjustments checked over %0d rounds",
                 requests_sent, adjustments, rounds);
        $display("node counts 0..127 incl. mid-round changes; mixed idling and one long hold");
        if (errors == 0) begin
            $display("clock_offset_averager_top_test: done, clean");
        end else begin
            $display("clock_offset_averager_top_test: done, errors");
        end
        $finish;
    end

endmodule
